FILE: sv/interrupt_event_queue_defines.svh
// Assertion macros for the interrupt event queue
`ifndef INTERRUPT_EVENT_QUEUE_DEFINES_SVH
`define INTERRUPT_EVENT_QUEUE_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle
`define IEQ_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define IEQ_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ieq_pkg.sv
package ieq_pkg;

	localparam int PIN_SLOTS      = 8;
	localparam int QUEUE_DEPTH    = 8;
	localparam int TIMER_CHANNELS = 4;
	localparam int SLOT_W  = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CH_W    = 2;
	localparam int BANK_BITS = 32;

	localparam logic [3:0] TRIG_LOW  = 4'd1;
	localparam logic [3:0] TRIG_HIGH = 4'd2;
	localparam logic [3:0] TRIG_FALL = 4'd4;
	localparam logic [3:0] TRIG_RISE = 4'd8;

	localparam logic [2:0] OP_EVENT = 3'd0;
	localparam logic [2:0] OP_PIN   = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_STOP  = 3'd3;
	localparam logic [2:0] OP_DRAIN = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_TRIG  = 2'd2;

	// queued source: timer flag plus index
	typedef struct packed {
		logic       is_timer;
		logic [3:0] idx;
	} src_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] pin_events_low;
		logic [31:0] pin_events_high;
		logic [31:0] pin_levels_low;
		logic [31:0] pin_levels_high;
		logic [3:0]  timer_matches;
		logic [5:0]  pin_number;
		logic [7:0]  trigger_bits;
		logic        pin_enable;
		logic [1:0]  channel;
		logic        periodic;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] timer_ack_mask;
		logic [3:0] rearm_mask;
		logic [3:0] pushed_count;
		logic [3:0] dropped_count;
		logic       popped_valid;
		logic       popped_is_timer;
		logic [2:0] popped_index;
		logic [5:0] popped_pin;
		logic [2:0] queue_level;
	} rsp_t;

endpackage

FILE: sv/ieq_if.sv
interface ieq_req_if;
	logic          valid;
	logic          ready;
	ieq_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ieq_rsp_if.sv
interface ieq_rsp_if;
	logic          valid;
	logic          ready;
	ieq_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ieq_front.sv
// Front end: accepts requests into a two-entry command queue
module ieq_front (
	input  logic          clk,
	input  logic          arst_n,
	ieq_req_if.sink       in_ch,
	output logic          cmd_valid,
	output ieq_pkg::req_t cmd,
	input  logic          cmd_take
);
	ieq_pkg::req_t buf_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign cmd_valid   = (cnt_q != 2'd0);
	assign cmd         = buf_q[rd_q];

	// command fifo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				buf_q[wr_q] <= in_ch.data;
				wr_q        <= ~wr_q;
			end
			if (cmd_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_ch.valid && in_ch.ready} - {1'b0, cmd_take};
		end
	end
endmodule

FILE: sv/ieq_back.sv
// Back end: sequencer that scans sources, searches slots, starts timers, pops and compacts the ring
module ieq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  ieq_pkg::req_t cmd,
	output logic          cmd_take,
	ieq_rsp_if.source     out_ch
);
	localparam int NSRC = ieq_pkg::TIMER_CHANNELS + ieq_pkg::PIN_SLOTS;
	localparam int SC_W = $clog2(NSRC + 1);

	typedef enum logic [2:0] {
		IDLE, EVT, SRCH, FLUSH, DONE
	} state_t;

	state_t              state_q;
	ieq_pkg::req_t       req_q;
	ieq_pkg::rsp_t       rsp_q;
	logic                ovalid_q;
	logic                slot_active_q [ieq_pkg::PIN_SLOTS];
	logic [5:0]          slot_pin_q [ieq_pkg::PIN_SLOTS];
	logic [3:0]          slot_trig_q [ieq_pkg::PIN_SLOTS];
	logic                tact_q [ieq_pkg::TIMER_CHANNELS];
	logic                tper_q [ieq_pkg::TIMER_CHANNELS];
	ieq_pkg::src_t       mem_q [ieq_pkg::QUEUE_DEPTH];
	logic [ieq_pkg::QPTR_W-1:0] head_q, tail_q, rp_q, wp_q;
	logic [SC_W-1:0]     idx_q;
	logic                found_q, fkind_q;
	logic [ieq_pkg::SLOT_W-1:0] slot_q;

	function automatic logic [ieq_pkg::QPTR_W-1:0] nxt(
		input logic [ieq_pkg::QPTR_W-1:0] p
	);
		nxt = (32'(p) + 1 >= ieq_pkg::QUEUE_DEPTH) ? '0 : p + 1'b1;
	endfunction

	function automatic logic pin_bit(input logic [31:0] lo, input logic [31:0] hi,
		input logic [5:0] p);
		pin_bit = p[5] ? hi[p[4:0]] : lo[p[4:0]];
	endfunction

	// per-scan-step combinational helpers
	logic                       src_fire, src_periodic;
	ieq_pkg::src_t              src_code;
	logic [ieq_pkg::SLOT_W-1:0] cur_slot;
	logic [1:0]                 cur_ch;
	logic                       lev;
	ieq_pkg::src_t              rd_src;
	logic                       drop_it;

	always_comb begin
		cur_slot     = '0;
		cur_ch       = '0;
		src_fire     = 1'b0;
		src_periodic = 1'b0;
		src_code     = '0;
		lev          = 1'b0;
		if (32'(idx_q) < ieq_pkg::TIMER_CHANNELS) begin
			cur_ch       = idx_q[1:0];
			src_fire     = req_q.timer_matches[cur_ch] && tact_q[cur_ch];
			src_periodic = tper_q[cur_ch];
			src_code     = '{is_timer: 1'b1, idx: {2'b00, cur_ch}};
		end else if (32'(idx_q) < NSRC) begin
			cur_slot = ieq_pkg::SLOT_W'(32'(idx_q) - ieq_pkg::TIMER_CHANNELS);
			lev      = pin_bit(req_q.pin_levels_low, req_q.pin_levels_high,
				slot_pin_q[cur_slot]);
			src_fire = slot_active_q[cur_slot] &&
				pin_bit(req_q.pin_events_low, req_q.pin_events_high,
					slot_pin_q[cur_slot]) &&
				((|(slot_trig_q[cur_slot] & (ieq_pkg::TRIG_RISE | ieq_pkg::TRIG_HIGH))
					&& lev) ||
				 (|(slot_trig_q[cur_slot] & (ieq_pkg::TRIG_FALL | ieq_pkg::TRIG_LOW))
					&& !lev));
			src_code = '{is_timer: 1'b0, idx: 4'(cur_slot)};
		end
		rd_src = mem_q[rp_q];
		if (fkind_q)
			drop_it = rd_src.is_timer && rd_src.idx == {2'b00, req_q.channel};
		else
			drop_it = !rd_src.is_timer && 32'(rd_src.idx) < ieq_pkg::PIN_SLOTS &&
				slot_pin_q[ieq_pkg::SLOT_W'(rd_src.idx)] == req_q.pin_number;
	end

	logic [ieq_pkg::QPTR_W-1:0] level;
	assign level = head_q - tail_q;

	ieq_pkg::src_t              tl_src;
	logic [ieq_pkg::SLOT_W-1:0] tl_slot;
	assign tl_src  = mem_q[tail_q];
	assign tl_slot = ieq_pkg::SLOT_W'(tl_src.idx);

	assign cmd_take     = (state_q == IDLE) && cmd_valid && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			ovalid_q <= 1'b0;
			rsp_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			for (int i = 0; i < ieq_pkg::PIN_SLOTS; i++) begin
				slot_active_q[i] <= 1'b0;
				slot_pin_q[i]    <= '0;
				slot_trig_q[i]   <= '0;
			end
			for (int i = 0; i < ieq_pkg::TIMER_CHANNELS; i++) begin
				tact_q[i] <= 1'b0;
				tper_q[i] <= 1'b0;
			end
		end else begin
			// response leaves: clear it for the next command
			if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
				rsp_q    <= '0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd_take) begin
						req_q   <= cmd;
						idx_q   <= '0;
						found_q <= 1'b0;
						slot_q  <= '0;
						rp_q    <= tail_q;
						wp_q    <= tail_q;
						unique case (cmd.op)
							ieq_pkg::OP_EVENT: state_q <= EVT;
							ieq_pkg::OP_PIN: state_q <= SRCH;
							ieq_pkg::OP_START: begin
								if (32'(cmd.channel) < ieq_pkg::TIMER_CHANNELS) begin
									tact_q[cmd.channel] <= 1'b1;
									tper_q[cmd.channel] <= cmd.periodic;
									rsp_q.timer_ack_mask <= 4'(4'd1 << cmd.channel);
								end
								state_q <= DONE;
							end
							ieq_pkg::OP_STOP: begin
								fkind_q <= 1'b1;
								state_q <= (32'(cmd.channel) < ieq_pkg::TIMER_CHANNELS)
									? FLUSH : DONE;
							end
							ieq_pkg::OP_DRAIN: begin
								if (head_q != tail_q) begin
									tail_q <= nxt(tail_q);
									if (tl_src.is_timer) begin
										if (32'(tl_src.idx) < ieq_pkg::TIMER_CHANNELS &&
											tact_q[tl_src.idx[1:0]]) begin
											rsp_q.popped_valid    <= 1'b1;
											rsp_q.popped_is_timer <= 1'b1;
											rsp_q.popped_index    <= 3'(tl_src.idx);
										end
									end else if (32'(tl_src.idx) < ieq_pkg::PIN_SLOTS &&
										slot_active_q[tl_slot]) begin
										rsp_q.popped_valid <= 1'b1;
										rsp_q.popped_index <= 3'(tl_src.idx);
										rsp_q.popped_pin   <= slot_pin_q[tl_slot];
									end
								end
								state_q <= DONE;
							end
							default: state_q <= DONE;
						endcase
					end
				end
				EVT: begin
					// one source per cycle: timers first, then pin slots
					if (32'(idx_q) >= NSRC) begin
						state_q <= DONE;
					end else begin
						if (32'(idx_q) < ieq_pkg::TIMER_CHANNELS &&
							req_q.timer_matches[cur_ch]) begin
							rsp_q.timer_ack_mask[cur_ch] <= 1'b1;
							if (tact_q[cur_ch] && src_periodic)
								rsp_q.rearm_mask[cur_ch] <= 1'b1;
						end
						if (src_fire) begin
							if (nxt(head_q) == tail_q) begin
								rsp_q.dropped_count <= rsp_q.dropped_count + 4'd1;
							end else begin
								mem_q[head_q] <= src_code;
								head_q <= nxt(head_q);
								rsp_q.pushed_count <= rsp_q.pushed_count + 4'd1;
							end
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				SRCH: begin
					// slot search, one slot per cycle
					if (32'(idx_q) >= ieq_pkg::PIN_SLOTS) begin
						if (!req_q.pin_enable) begin
							if (found_q && slot_pin_q[slot_q] == req_q.pin_number) begin
								fkind_q <= 1'b0;
								state_q <= FLUSH;
							end else begin
								state_q <= DONE;
							end
						end else if (!found_q) begin
							rsp_q.status <= ieq_pkg::ST_FULL;
							state_q <= DONE;
						end else if (|req_q.trigger_bits[7:4]) begin
							rsp_q.status <= ieq_pkg::ST_TRIG;
							state_q <= DONE;
						end else begin
							slot_pin_q[slot_q]    <= req_q.pin_number;
							slot_trig_q[slot_q]   <= req_q.trigger_bits[3:0];
							slot_active_q[slot_q] <= 1'b1;
							state_q <= DONE;
						end
					end else begin
						if (slot_active_q[ieq_pkg::SLOT_W'(idx_q)] &&
							slot_pin_q[ieq_pkg::SLOT_W'(idx_q)] == req_q.pin_number) begin
							slot_q  <= ieq_pkg::SLOT_W'(idx_q);
							found_q <= 1'b1;
							idx_q   <= SC_W'(ieq_pkg::PIN_SLOTS);
						end else begin
							if (!found_q && !slot_active_q[ieq_pkg::SLOT_W'(idx_q)]) begin
								slot_q  <= ieq_pkg::SLOT_W'(idx_q);
								found_q <= 1'b1;
							end
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				FLUSH: begin
					// in-place compaction, one entry per cycle
					if (rp_q == head_q) begin
						head_q <= wp_q;
						if (fkind_q) begin
							tact_q[req_q.channel[1:0]] <= 1'b0;
							rsp_q.timer_ack_mask <= 4'(4'd1 << req_q.channel);
						end else begin
							slot_active_q[slot_q] <= 1'b0;
						end
						state_q <= DONE;
					end else begin
						if (!drop_it) begin
							mem_q[wp_q] <= rd_src;
							wp_q <= nxt(wp_q);
						end
						rp_q <= nxt(rp_q);
					end
				end
				DONE: begin
					if (!ovalid_q) begin
						rsp_q.queue_level <= 3'(level);
						ovalid_q <= 1'b1;
						state_q  <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

FILE: sv/interrupt_event_queue.sv
// Channel  Dir  Payload
// in_ch    in   op, pin event/level banks, timer matches, pin/trigger, channel
// out_ch   out  status, ack/rearm masks, push/drop counts, popped source, level
//
// Commands pass through a two-entry command queue, which keeps accepting
// while the sequencer works. An event scans every timer and pin slot, a
// register or unregister searches the slots, and an unregister or stop
// then compacts the ring. Reset clears tables and pointers.
// A stalled output holds the sequencer before its next command.
`include "interrupt_event_queue_defines.svh"
module interrupt_event_queue (
	input  logic      clk,
	input  logic      arst_n,
	ieq_req_if.sink   in_ch,
	ieq_rsp_if.source out_ch
);
	logic          cmd_valid, cmd_take;
	ieq_pkg::req_t cmd;

	ieq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	ieq_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .out_ch(out_ch)
	);

	`IEQ_ASSERT_IMP(a_take_valid, clk, arst_n, cmd_take, cmd_valid, "take without command")
	`IEQ_ASSERT_IMP(a_status_ok, clk, arst_n, out_ch.valid, out_ch.data.status != 2'd3, "bad status")
	`IEQ_ASSERT_IMP(a_pop_flag, clk, arst_n, out_ch.valid && out_ch.data.popped_is_timer, out_ch.data.popped_valid, "timer flag without pop")
endmodule

FILE: verif/interrupt_event_queue_checker.sv
`timescale 1ns / 100ps

module interrupt_event_queue_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  ieq_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  ieq_pkg::rsp_t rsp_data,
	output int            fail_count,
	output int            pending_count,
	output int            result_count
);

	// shadow of the block's tables and ring
	logic          slot_on [ieq_pkg::PIN_SLOTS];
	logic [5:0]    slot_pin_num [ieq_pkg::PIN_SLOTS];
	logic [3:0]    slot_trig [ieq_pkg::PIN_SLOTS];
	logic          tmr_on [ieq_pkg::TIMER_CHANNELS];
	logic          tmr_per [ieq_pkg::TIMER_CHANNELS];
	ieq_pkg::src_t ring [ieq_pkg::QUEUE_DEPTH];
	int            ring_head;
	int            ring_tail;

	ieq_pkg::rsp_t expected_rsps[$];

	function automatic int ring_next(int p);
		return (p + 1 >= ieq_pkg::QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic bit ring_push(ieq_pkg::src_t s);
		int nx;
		nx = ring_next(ring_head);
		if (nx == ring_tail)
			return 0;
		ring[ring_head] = s;
		ring_head = nx;
		return 1;
	endfunction

	// compact the ring in order, removing matching sources
	function automatic void ring_flush(bit by_timer, int key);
		int w;
		int r;
		bit drop;
		w = ring_tail;
		r = ring_tail;
		while (r != ring_head) begin
			if (by_timer)
				drop = ring[r].is_timer && ring[r].idx == key;
			else
				drop = !ring[r].is_timer && ring[r].idx < ieq_pkg::PIN_SLOTS &&
					slot_pin_num[ieq_pkg::SLOT_W'(ring[r].idx)] == key;
			if (!drop) begin
				ring[w] = ring[r];
				w = ring_next(w);
			end
			r = ring_next(r);
		end
		ring_head = w;
	endfunction

	function automatic ieq_pkg::rsp_t handle_request(ieq_pkg::req_t q);
		ieq_pkg::rsp_t rs;
		int slot;
		logic [63:0] ev;
		logic [63:0] lv;
		logic lev;
		ieq_pkg::src_t s;
		rs = '0;
		ev = {q.pin_events_high, q.pin_events_low};
		lv = {q.pin_levels_high, q.pin_levels_low};
		case (q.op)
			ieq_pkg::OP_EVENT: begin
				for (int i = 0; i < ieq_pkg::TIMER_CHANNELS; i++) begin
					if (!q.timer_matches[i])
						continue;
					rs.timer_ack_mask[i] = 1'b1;
					if (!tmr_on[i])
						continue;
					if (tmr_per[i])
						rs.rearm_mask[i] = 1'b1;
					s.is_timer = 1'b1;
					s.idx = 4'(i);
					if (ring_push(s))
						rs.pushed_count++;
					else
						rs.dropped_count++;
				end
				for (int i = 0; i < ieq_pkg::PIN_SLOTS; i++) begin
					if (!slot_on[i] || !ev[slot_pin_num[i]])
						continue;
					lev = lv[slot_pin_num[i]];
					if (!(((slot_trig[i] & (ieq_pkg::TRIG_RISE | ieq_pkg::TRIG_HIGH)) != 0
						&& lev) ||
						((slot_trig[i] & (ieq_pkg::TRIG_FALL | ieq_pkg::TRIG_LOW)) != 0
						&& !lev)))
						continue;
					s.is_timer = 1'b0;
					s.idx = 4'(i);
					if (ring_push(s))
						rs.pushed_count++;
					else
						rs.dropped_count++;
				end
			end
			ieq_pkg::OP_PIN: begin
				slot = -1;
				for (int i = 0; i < ieq_pkg::PIN_SLOTS; i++) begin
					if (slot_on[i] && slot_pin_num[i] == q.pin_number) begin
						slot = i;
						break;
					end
					if (slot < 0 && !slot_on[i])
						slot = i;
				end
				if (!q.pin_enable) begin
					if (slot >= 0 && slot_pin_num[slot] == q.pin_number) begin
						ring_flush(1'b0, q.pin_number);
						slot_on[slot] = 1'b0;
					end
				end else if (slot < 0) begin
					rs.status = ieq_pkg::ST_FULL;
				end else if (q.trigger_bits[7:4] != 0) begin
					rs.status = ieq_pkg::ST_TRIG;
				end else begin
					slot_pin_num[slot] = q.pin_number;
					slot_trig[slot] = q.trigger_bits[3:0];
					slot_on[slot] = 1'b1;
				end
			end
			ieq_pkg::OP_START, ieq_pkg::OP_STOP: begin
				if (q.channel < ieq_pkg::TIMER_CHANNELS) begin
					if (q.op == ieq_pkg::OP_START) begin
						tmr_on[q.channel] = 1'b1;
						tmr_per[q.channel] = q.periodic;
					end else begin
						ring_flush(1'b1, q.channel);
						tmr_on[q.channel] = 1'b0;
					end
					rs.timer_ack_mask[q.channel] = 1'b1;
				end
			end
			ieq_pkg::OP_DRAIN: begin
				if (ring_tail != ring_head) begin
					s = ring[ring_tail];
					ring_tail = ring_next(ring_tail);
					if (s.is_timer) begin
						if (s.idx < ieq_pkg::TIMER_CHANNELS && tmr_on[s.idx[1:0]]) begin
							rs.popped_valid = 1'b1;
							rs.popped_is_timer = 1'b1;
							rs.popped_index = 3'(s.idx);
						end
					end else if (s.idx < ieq_pkg::PIN_SLOTS &&
						slot_on[ieq_pkg::SLOT_W'(s.idx)]) begin
						rs.popped_valid = 1'b1;
						rs.popped_index = 3'(s.idx);
						rs.popped_pin = slot_pin_num[ieq_pkg::SLOT_W'(s.idx)];
					end
				end
			end
			default: ;
		endcase
		rs.queue_level = 3'((ring_head + ieq_pkg::QUEUE_DEPTH - ring_tail)
			% ieq_pkg::QUEUE_DEPTH);
		return rs;
	endfunction

	assign pending_count = expected_rsps.size();

	// predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		ieq_pkg::rsp_t exp_rsp;
		if (!arst_n) begin
			for (int i = 0; i < ieq_pkg::PIN_SLOTS; i++) begin
				slot_on[i] = 1'b0;
				slot_pin_num[i] = '0;
				slot_trig[i] = '0;
			end
			for (int i = 0; i < ieq_pkg::TIMER_CHANNELS; i++) begin
				tmr_on[i] = 1'b0;
				tmr_per[i] = 1'b0;
			end
			ring_head = 0;
			ring_tail = 0;
			expected_rsps.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsps.push_back(handle_request(req_data));
			if (rsp_valid && rsp_ready) begin
				result_count++;
				if (expected_rsps.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %p", $time, rsp_data);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_data !== exp_rsp) begin
						fail_count++;
						$display("%0t: mismatch expected %p actual %p",
							$time, exp_rsp, rsp_data);
					end
				end
			end
		end
	end

endmodule

FILE: verif/interrupt_event_queue_tb.sv
`timescale 1ns / 100ps

module interrupt_event_queue_tb;

	localparam int RANDOM_ITEMS = 1530;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int CALM_TAIL = 200;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_count;
	int   result_count;
	int   sent_count;
	int   idle_cycles;
	bit   stim_done;
	bit   calm;
	bit   hold_sink;

	ieq_req_if in_ch ();
	ieq_rsp_if out_ch ();

	interrupt_event_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	interrupt_event_queue_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (in_ch.valid),
		.req_ready     (in_ch.ready),
		.req_data      (in_ch.data),
		.rsp_valid     (out_ch.valid),
		.rsp_ready     (out_ch.ready),
		.rsp_data      (out_ch.data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// random pin chosen mostly from a small set so events hit registered slots
	function automatic logic [5:0] pick_pin();
		if ($urandom_range(0, 3) != 0)
			return 6'($urandom_range(0, 3) * 21);
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic ieq_pkg::req_t random_req();
		ieq_pkg::req_t q;
		int sel;
		q.op = 3'($urandom_range(0, 7));
		q.pin_events_low = $urandom();
		q.pin_events_high = $urandom();
		q.pin_levels_low = $urandom();
		q.pin_levels_high = $urandom();
		q.timer_matches = 4'($urandom());
		q.pin_number = pick_pin();
		q.trigger_bits = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15));
		q.pin_enable = ($urandom_range(0, 3) != 0);
		q.channel = 2'($urandom());
		q.periodic = 1'($urandom());
		// weight toward events and drains, rest spread over other ops
		sel = $urandom_range(0, 99);
		if (sel < 35)
			q.op = ieq_pkg::OP_EVENT;
		else if (sel < 65)
			q.op = ieq_pkg::OP_DRAIN;
		else if (sel < 80)
			q.op = ieq_pkg::OP_PIN;
		else if (sel < 87)
			q.op = ieq_pkg::OP_START;
		else if (sel < 94)
			q.op = ieq_pkg::OP_STOP;
		return q;
	endfunction

	function automatic ieq_pkg::req_t make_req(logic [2:0] op, logic [5:0] pin,
		logic [7:0] trig, logic en, logic [1:0] ch, logic per, logic [3:0] match_bits,
		logic [63:0] ev, logic [63:0] lv);
		ieq_pkg::req_t q;
		q.op = op;
		q.pin_number = pin;
		q.trigger_bits = trig;
		q.pin_enable = en;
		q.channel = ch;
		q.periodic = per;
		q.timer_matches = match_bits;
		{q.pin_events_high, q.pin_events_low} = ev;
		{q.pin_levels_high, q.pin_levels_low} = lv;
		return q;
	endfunction

	// one transaction with an optional random gap ahead of it
	task automatic send_req(ieq_pkg::req_t q);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= q;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	// sink side: random stall bursts, one long hold-off on request
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 19);
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if (arst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			&& !hold_sink && !(stim_done && pending_count == 0)) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	initial begin
		logic [63:0] all_ones;
		all_ones = '1;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		sent_count = 0;
		idle_cycles = 0;
		stim_done = 0;
		calm = 0;
		hold_sink = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: drain empty, registrations, full slots, bad trigger
		send_req(make_req(ieq_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 0, ieq_pkg::TRIG_RISE, 1, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 63, ieq_pkg::TRIG_LOW, 1, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 5, 8'hFF, 1, 0, 0, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			send_req(make_req(ieq_pkg::OP_PIN, 6'(10 + i),
				ieq_pkg::TRIG_FALL | ieq_pkg::TRIG_HIGH, 1, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 40, ieq_pkg::TRIG_HIGH, 1, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 0, ieq_pkg::TRIG_FALL, 1, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_START, 0, 0, 0, 0, 1, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_START, 0, 0, 0, 3, 0, 0, 0, 0));
		// events fill the ring past capacity, levels both ways
		send_req(make_req(ieq_pkg::OP_EVENT, 0, 0, 0, 0, 0, 4'hF, all_ones, all_ones));
		send_req(make_req(ieq_pkg::OP_EVENT, 0, 0, 0, 0, 0, 4'hF, all_ones, 0));
		send_req(make_req(ieq_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_STOP, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 63, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_PIN, 33, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(ieq_pkg::OP_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(3'd7, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(make_req(3'd5, 0, 0, 0, 0, 0, 0, 0, 0));

		// random part; long sink hold-off near the start
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100)
				hold_sink = 1'b1;
			if (n == RANDOM_ITEMS - CALM_TAIL)
				calm = 1'b1;
			send_req(random_req());
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;

		while (pending_count != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d transactions, checked %0d results", sent_count, result_count);
		$display("covered events, pin and timer ops, drains, ring overflow and flushes");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
